/* hdl/deqs_pkg.sv */
// Shared types and constants for the double-ended queue with search.
package deqs_pkg;

    localparam int MODE_W   = 3;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH_FRONT = 3'd0,
        MODE_PUSH_BACK  = 3'd1,
        MODE_POP_FRONT  = 3'd2,
        MODE_POP_BACK   = 3'd3,
        MODE_PEEK_FRONT = 3'd4,
        MODE_PEEK_BACK  = 3'd5,
        MODE_FIND       = 3'd6,
        MODE_REMOVE     = 3'd7
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

endpackage

/* hdl/deqs_ifs.sv */
// Request and response channel interfaces of the double-ended queue.
interface deqs_req_if import deqs_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [MODE_W-1:0]   mode;
    logic [WORD_W-1:0]   item_value;

    modport source (output valid, output mode, output item_value, input ready);
    modport sink   (input valid, input mode, input item_value, output ready);
endinterface

interface deqs_rsp_if import deqs_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [WORD_W-1:0]   result_value;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  entry_count;

    modport source (output valid, output result_value, output status,
                    output entry_count, input ready);
    modport sink   (input valid, input result_value, input status,
                    input entry_count, output ready);
endinterface

/* hdl/deqs_ram.sv */
// Ring store: one write port, one read port with registered read data.
module deqs_ram #(
    parameter  int DEPTH = 16,
    parameter  int DW    = 32,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/double_ended_queue_with_search_top.sv */
// Double-ended queue with search: sequencer around a ring store.
//
// Channels: i_req carries mode and item_value; o_rsp returns result_value,
// status and entry_count, one response for every request.
// i_req.ready is high only while the sequencer is idle; one request is
// worked on at a time, and every store access goes through the single
// read port and single write port of the ring store.
// States that a request passes through before its response is loaded:
//   push front/back, or any refused request: S_EXEC, then S_RESP
//   pop/peek front/back: S_EXEC, S_READ (one store read), then S_RESP
//   find: S_EXEC, then S_SCAN compares entries from the front up to the match,
//         or through every entry when nothing matches, then S_RESP
//   remove match: scan to the match, then in S_SHIFT one entry moved
//         toward the front each cycle, then S_RESP
// The next request is taken the cycle after the response is loaded.
// The response sits in an output register; when the receiver stalls it is
// held and a finished request waits in the sequencer until it is taken.
// Reset (synchronous, active low) empties the queue: front and count go to
// zero, no response is pending. Store contents are not cleared.
module double_ended_queue_with_search_top import deqs_pkg::*; #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    deqs_req_if.sink   i_req,
    deqs_rsp_if.source o_rsp
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_READ,
        S_SCAN,
        S_SHIFT,
        S_RESP
    } t_state;

    t_state                r_state, n_state;
    t_mode                 r_mode, n_mode;
    logic [DATA_WIDTH-1:0] r_key, n_key;
    logic [AW-1:0]         r_front, n_front;
    logic [CW-1:0]         r_count, n_count;
    logic [CW-1:0]         r_idx, n_idx;
    logic [CW-1:0]         r_pidx, n_pidx;
    logic                  r_pend, n_pend;
    logic [DATA_WIDTH-1:0] r_res_value, n_res_value;
    t_status               r_res_status, n_res_status;
    logic                  r_out_valid, n_out_valid;
    logic [WORD_W-1:0]     r_out_value, n_out_value;
    t_status               r_out_status, n_out_status;
    logic [COUNT_W-1:0]    r_out_count, n_out_count;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [DATA_WIDTH-1:0] ram_wdata;
    logic [AW-1:0]         ram_raddr;
    logic [DATA_WIDTH-1:0] ram_rdata;

    logic [AW-1:0]         front_dec;
    logic [AW-1:0]         front_inc;

    function automatic logic [AW-1:0] f_slot(logic [AW-1:0] front, logic [CW:0] off);
        logic [CW+1:0] sum;
        sum = (CW+2)'(front) + (CW+2)'(off);
        if (sum >= (CW+2)'(DEPTH)) begin
            sum = sum - (CW+2)'(DEPTH);
        end
        return AW'(sum);
    endfunction

    deqs_ram #(
        .DEPTH (DEPTH),
        .DW    (DATA_WIDTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign front_dec = (r_front == '0) ? AW'(DEPTH - 1) : r_front - AW'(1);
    assign front_inc = (r_front == AW'(DEPTH - 1)) ? '0 : r_front + AW'(1);

    assign i_req.ready        = (r_state == S_IDLE);
    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.result_value = r_out_value;
    assign o_rsp.status       = r_out_status;
    assign o_rsp.entry_count  = r_out_count;

    always_comb begin
        n_state      = r_state;
        n_mode       = r_mode;
        n_key        = r_key;
        n_front      = r_front;
        n_count      = r_count;
        n_idx        = r_idx;
        n_pidx       = r_pidx;
        n_pend       = r_pend;
        n_res_value  = r_res_value;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out_value  = r_out_value;
        n_out_status = r_out_status;
        n_out_count  = r_out_count;
        ram_we       = 1'b0;
        ram_waddr    = r_front;
        ram_wdata    = r_key;
        ram_raddr    = r_front;

        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_mode  = t_mode'(i_req.mode);
                    n_key   = DATA_WIDTH'(i_req.item_value);
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_res_value  = '0;
                n_res_status = ST_OK;
                n_pend       = 1'b0;
                n_idx        = '0;
                n_state      = S_RESP;
                if (r_mode inside {MODE_PUSH_FRONT, MODE_PUSH_BACK}) begin
                    if (r_count == CW'(DEPTH)) begin
                        n_res_status = ST_FULL;
                    end else begin
                        ram_we  = 1'b1;
                        n_count = r_count + CW'(1);
                        if (r_mode == MODE_PUSH_FRONT) begin
                            ram_waddr = front_dec;
                            n_front   = front_dec;
                        end else begin
                            ram_waddr = f_slot(r_front, {1'b0, r_count});
                        end
                    end
                end else if (r_mode inside {MODE_POP_FRONT, MODE_POP_BACK,
                                            MODE_PEEK_FRONT, MODE_PEEK_BACK}) begin
                    if (r_count == '0) begin
                        n_res_status = ST_EMPTY;
                    end else begin
                        if (r_mode inside {MODE_POP_BACK, MODE_PEEK_BACK}) begin
                            ram_raddr = f_slot(r_front, {1'b0, r_count - CW'(1)});
                        end
                        n_state = S_READ;
                    end
                end else begin
                    if (r_count == '0) begin
                        n_res_status = ST_NOT_FOUND;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_READ: begin
                n_res_value = ram_rdata;
                if (r_mode == MODE_POP_FRONT) begin
                    n_front = front_inc;
                    n_count = r_count - CW'(1);
                end else if (r_mode == MODE_POP_BACK) begin
                    n_count = r_count - CW'(1);
                end
                n_state = S_RESP;
            end
            S_SCAN: begin
                // read one entry ahead, compare the one read last cycle
                ram_raddr = f_slot(r_front, {1'b0, r_idx});
                n_idx     = r_idx + CW'(1);
                n_pidx    = r_idx;
                n_pend    = 1'b1;
                if (r_pend) begin
                    if (ram_rdata == r_key) begin
                        n_res_value = ram_rdata;
                        if (r_mode == MODE_REMOVE) begin
                            if (r_pidx + CW'(1) == r_count) begin
                                n_count = r_count - CW'(1);
                                n_state = S_RESP;
                            end else begin
                                n_idx   = r_pidx;
                                n_state = S_SHIFT;
                            end
                        end else begin
                            n_state = S_RESP;
                        end
                    end else if (r_pidx + CW'(1) == r_count) begin
                        n_res_status = ST_NOT_FOUND;
                        n_state      = S_RESP;
                    end
                end
            end
            S_SHIFT: begin
                // data of entry idx+1 moves into entry idx
                ram_we    = 1'b1;
                ram_waddr = f_slot(r_front, {1'b0, r_idx});
                ram_wdata = ram_rdata;
                ram_raddr = f_slot(r_front, (CW+1)'(r_idx) + (CW+1)'(2));
                n_idx     = r_idx + CW'(1);
                if ((CW+1)'(r_idx) + (CW+1)'(2) == (CW+1)'(r_count)) begin
                    n_count = r_count - CW'(1);
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_value  = WORD_W'(r_res_value);
                    n_out_status = r_res_status;
                    n_out_count  = COUNT_W'(r_count);
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_mode       <= n_mode;
        r_key        <= n_key;
        r_idx        <= n_idx;
        r_pidx       <= n_pidx;
        r_res_value  <= n_res_value;
        r_res_status <= n_res_status;
        r_out_value  <= n_out_value;
        r_out_status <= n_out_status;
        r_out_count  <= n_out_count;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_front     <= '0;
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_front     <= n_front;
            r_count     <= n_count;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above depth");

    a_front_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_front <= AW'(DEPTH - 1))
        else $error("front index out of range");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status == ST_FULL) |-> r_out_count == COUNT_W'(DEPTH))
        else $error("full status with room left");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status == ST_EMPTY) |-> r_out_count == '0)
        else $error("empty status with entries left");

    a_busy_no_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN || r_state == S_SHIFT) |-> r_count != '0)
        else $error("search running on empty queue");

endmodule

/* verif/testbench.sv */
// Testbench for the double-ended queue with search: directed and random requests checked against a behavioral deque.
module testbench;
    import deqs_pkg::*;

    localparam int DEPTH          = 16;
    localparam int RANDOM_ITEMS   = 1920;
    localparam int MAX_GAP        = 8;
    localparam int TAIL_CYCLES    = 40;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int REPORT_LIMIT   = 10;

    typedef struct {
        logic [WORD_W-1:0]  word;
        t_status            status;
        logic [COUNT_W-1:0] count;
    } t_answer;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    deqs_req_if req_if ();
    deqs_rsp_if rsp_if ();

    double_ended_queue_with_search_top #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (WORD_W)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    always #10 i_clk = ~i_clk;

    // behavioral deque
    logic [WORD_W-1:0] shadow_ring [DEPTH];
    int unsigned       shadow_head = 0;
    int unsigned       shadow_fill = 0;
    t_answer           answers_due [$];

    int  fail_count  = 0;
    int  idle_cycles = 0;
    bit  quiet       = 1'b0;

    function automatic int unsigned ring_slot(int unsigned offset);
        return (shadow_head + offset) % DEPTH;
    endfunction

    function automatic void note_failure(string msg);
        fail_count++;
        if (fail_count <= REPORT_LIMIT) begin
            $display("%s", msg);
        end
    endfunction

    function automatic void apply_request(t_mode m, logic [WORD_W-1:0] w);
        t_answer a;
        int      pos;
        a.word   = '0;
        a.status = ST_OK;
        pos      = -1;
        case (m)
            MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
                if (shadow_fill >= DEPTH) begin
                    a.status = ST_FULL;
                end else if (m == MODE_PUSH_FRONT) begin
                    shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
                    shadow_ring[shadow_head] = w;
                    shadow_fill++;
                end else begin
                    shadow_ring[ring_slot(shadow_fill)] = w;
                    shadow_fill++;
                end
            end
            MODE_POP_FRONT, MODE_POP_BACK, MODE_PEEK_FRONT, MODE_PEEK_BACK: begin
                if (shadow_fill == 0) begin
                    a.status = ST_EMPTY;
                end else if (m == MODE_POP_FRONT || m == MODE_PEEK_FRONT) begin
                    a.word = shadow_ring[shadow_head];
                    if (m == MODE_POP_FRONT) begin
                        shadow_head = (shadow_head + 1) % DEPTH;
                        shadow_fill--;
                    end
                end else begin
                    a.word = shadow_ring[ring_slot(shadow_fill - 1)];
                    if (m == MODE_POP_BACK) begin
                        shadow_fill--;
                    end
                end
            end
            default: begin
                for (int i = 0; i < shadow_fill; i++) begin
                    if (pos < 0 && shadow_ring[ring_slot(i)] == w) begin
                        pos = i;
                    end
                end
                if (pos < 0) begin
                    a.status = ST_NOT_FOUND;
                end else begin
                    a.word = shadow_ring[ring_slot(pos)];
                    if (m == MODE_REMOVE) begin
                        // close the gap toward the front
                        for (int j = pos; j + 1 < shadow_fill; j++) begin
                            shadow_ring[ring_slot(j)] = shadow_ring[ring_slot(j + 1)];
                        end
                        shadow_fill--;
                    end
                end
            end
        endcase
        a.count = COUNT_W'(shadow_fill);
        answers_due.push_back(a);
    endfunction

    function automatic int idle_draw();
        return quiet ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    function automatic logic [WORD_W-1:0] data_word();
        case ($urandom_range(0, 3))
            0:       return WORD_W'($urandom_range(0, 7));
            1:       return $urandom_range(0, 1) ? '1 : '0;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_request(t_mode m, logic [WORD_W-1:0] w);
        int gap;
        gap = idle_draw();
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid      <= 1'b1;
        req_if.mode       <= m;
        req_if.item_value <= w;
        do @(posedge i_clk); while (req_if.ready !== 1'b1);
        apply_request(m, w);
    endtask

    task automatic wait_drained();
        req_if.valid <= 1'b0;
        do @(negedge i_clk); while (answers_due.size() != 0);
        @(posedge i_clk);
    endtask

    task automatic test_empty_refusals();
        send_request(MODE_POP_FRONT, '1);
        send_request(MODE_POP_BACK, '0);
        send_request(MODE_PEEK_FRONT, '0);
        send_request(MODE_PEEK_BACK, '1);
        send_request(MODE_FIND, '0);
        send_request(MODE_REMOVE, '1);
    endtask

    function automatic logic [WORD_W-1:0] fill_word(int i);
        if (i == 0) return '0;
        if (i == 1) return '1;
        if (i == 6 || i == 10) return 32'hA5A5_5A5A;
        return 32'h1 << (i + 14);
    endfunction

    task automatic test_fill_and_refuse();
        for (int i = 0; i < DEPTH; i++) begin
            send_request(i[0] ? MODE_PUSH_BACK : MODE_PUSH_FRONT, fill_word(i));
        end
        send_request(MODE_PUSH_FRONT, 32'hDEAD_0001);
        send_request(MODE_PUSH_BACK, 32'hDEAD_0002);
    endtask

    task automatic test_search_and_ends();
        send_request(MODE_FIND, fill_word(DEPTH - 1));
        send_request(MODE_REMOVE, 32'hA5A5_5A5A);
        send_request(MODE_POP_FRONT, '0);
        send_request(MODE_POP_BACK, '0);
    endtask

    task automatic test_random(int n);
        int                target;
        int                pick;
        t_mode             m;
        logic [WORD_W-1:0] w;
        target = DEPTH / 2;
        for (int k = 0; k < n; k++) begin
            if (k % 64 == 0) begin
                target = $urandom_range(0, DEPTH);
                quiet  = ($urandom_range(0, 3) == 0);
            end
            if (k % 400 == 399) begin
                wait_drained();
            end
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                if (shadow_fill < target || (shadow_fill == target && $urandom_range(0, 1)))
                    m = $urandom_range(0, 1) ? MODE_PUSH_BACK : MODE_PUSH_FRONT;
                else
                    m = $urandom_range(0, 1) ? MODE_POP_BACK : MODE_POP_FRONT;
            end else if (pick < 52) begin
                m = $urandom_range(0, 1) ? MODE_PEEK_BACK : MODE_PEEK_FRONT;
            end else if (pick < 72) begin
                m = MODE_FIND;
            end else if (pick < 88) begin
                m = MODE_REMOVE;
            end else begin
                m = t_mode'($urandom_range(0, 7));
            end
            if ((m == MODE_FIND || m == MODE_REMOVE) && shadow_fill > 0
                    && $urandom_range(0, 3) != 0)
                w = shadow_ring[ring_slot($urandom_range(0, shadow_fill - 1))];
            else
                w = data_word();
            send_request(m, w);
        end
        quiet = 1'b0;
    endtask

    initial begin
        req_if.valid      <= 1'b0;
        req_if.mode       <= MODE_PUSH_FRONT;
        req_if.item_value <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_refusals();
        wait_drained();
        test_fill_and_refuse();
        wait_drained();
        test_search_and_ends();
        wait_drained();
        test_random(RANDOM_ITEMS);
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (answers_due.size() != 0) begin
            note_failure($sformatf("%0d responses never arrived", answers_due.size()));
        end
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // response side stalls
    initial begin : rsp_stall
        int stall;
        rsp_if.ready <= 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            stall = idle_draw();
            if (stall > 0) begin
                rsp_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rsp_if.ready <= 1'b1;
            do @(posedge i_clk); while (rsp_if.valid !== 1'b1);
        end
    end

    always @(posedge i_clk) begin : rsp_check
        t_answer want;
        if (i_rst_n && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            if (answers_due.size() == 0) begin
                note_failure($sformatf("unexpected response value=%h status=%0d count=%0d",
                    rsp_if.result_value, rsp_if.status, rsp_if.entry_count));
            end else begin
                want = answers_due.pop_front();
                if (rsp_if.result_value !== want.word)
                    note_failure($sformatf("result_value: expected %h, got %h",
                        want.word, rsp_if.result_value));
                if (rsp_if.status !== want.status)
                    note_failure($sformatf("status: expected %0d, got %0d",
                        want.status, rsp_if.status));
                if (rsp_if.entry_count !== want.count)
                    note_failure($sformatf("entry_count: expected %0d, got %0d",
                        want.count, rsp_if.entry_count));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((req_if.valid === 1'b1 && req_if.ready === 1'b1)
                || (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

endmodule

/* filelist.f */
hdl/deqs_pkg.sv
hdl/deqs_ifs.sv
hdl/deqs_ram.sv
hdl/double_ended_queue_with_search_top.sv
verif/testbench.sv
